// ===== rtl/bds_pkg.sv =====
// Shared types and constants of the 2x2 box downsampler.
// No dependencies; the interfaces, bds_cfg_regs and the top level import this package.
package bds_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 2;
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH   = 2'd0,
    REG_IN_HEIGHT  = 2'd1,
    REG_COLOR_MODE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] chan_a;
    logic [SAMPLE_W-1:0] chan_b;
    logic [SAMPLE_W-1:0] chan_c;
  } pix_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_a;
    logic [SAMPLE_W-1:0] avg_b;
    logic [SAMPLE_W-1:0] avg_c;
    logic                frame_last;
  } avg_t;

  typedef struct packed {
    logic [ROW_W-1:0] hlast;
    logic [ROW_W-1:0] hlast_even;
    logic             color;
  } frm_cfg_t;

endpackage

// ===== rtl/bds_pix_if.sv =====
// Input pixel channel: valid/ready handshake carrying one RGB or gray pixel.
// Depends on bds_pkg.
interface bds_pix_if;
  import bds_pkg::*;
  logic valid;
  logic ready;
  pix_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bds_avg_if.sv =====
// Result channel: valid/ready handshake carrying one averaged pixel.
// Depends on bds_pkg.
interface bds_avg_if;
  import bds_pkg::*;
  logic valid;
  logic ready;
  avg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bds_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on bds_pkg.
interface bds_cfg_if;
  import bds_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DIM_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bds_cfg_regs.sv =====
// Configuration registers; frame sizes are clamped and turned into wrap limits on write.
// Depends on bds_pkg and bds_cfg_if.
module bds_cfg_regs #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bds_cfg_if.sink                       cfg,
  output logic [$clog2(MAX_WIDTH)-1:0]  wlast,
  output logic [$clog2(MAX_WIDTH)-1:0]  wlast_even,
  output bds_pkg::frm_cfg_t             frm
);
  import bds_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CW-1:0] wlast_r, wlast_nxt;
  logic [CW-1:0] wlast_even_r, wlast_even_nxt;
  frm_cfg_t      frm_r, frm_nxt;

  function automatic logic [2*CW-1:0] width_limits(input logic [CFG_DIM_W-1:0] v);
    int unsigned w;
    w = 32'(v);
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return {CW'(w - 1), CW'((w & 32'hFFFF_FFFE) - 1)};
  endfunction

  function automatic logic [2*ROW_W-1:0] height_limits(input logic [CFG_DIM_W-1:0] v);
    int unsigned h;
    h = 32'(v);
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return {ROW_W'(h - 1), ROW_W'((h & 32'hFFFF_FFFE) - 1)};
  endfunction

  assign cfg.ready = 1'b1;

  always_comb begin
    wlast_nxt      = wlast_r;
    wlast_even_nxt = wlast_even_r;
    frm_nxt        = frm_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        REG_IN_WIDTH:   {wlast_nxt, wlast_even_nxt} = width_limits(cfg.data);
        REG_IN_HEIGHT:  {frm_nxt.hlast, frm_nxt.hlast_even} = height_limits(cfg.data);
        REG_COLOR_MODE: frm_nxt.color = cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {wlast_r, wlast_even_r}         <= width_limits(CFG_DIM_W'(RST_WIDTH));
      {frm_r.hlast, frm_r.hlast_even} <= height_limits(CFG_DIM_W'(RST_HEIGHT));
      frm_r.color                     <= 1'b1;
    end else begin
      wlast_r      <= wlast_nxt;
      wlast_even_r <= wlast_even_nxt;
      frm_r        <= frm_nxt;
    end
  end

  assign wlast      = wlast_r;
  assign wlast_even = wlast_even_r;
  assign frm        = frm_r;

endmodule

// ===== rtl/bds_line_mem.sv =====
// Line store of horizontal pair sums: one write port, one read port, registered read data.
// No dependencies.
module bds_line_mem #(
  parameter int DEPTH = 2048,
  parameter int DW    = 51
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/box_downsample_2x2.sv =====
// Top level of the 2x2 box downsampler: counters, pair sums, line store access, output stage.
// Depends on bds_pkg, the three channel interfaces, bds_cfg_regs and bds_line_mem.
//
//   port      dir   beat
//   in_pix    sink  one input pixel (chan_a, chan_b, chan_c), raster order
//   out_avg   src   one 2x2 mean (avg_a, avg_b, avg_c, frame_last)
//   cfg_wr    sink  register write (index, data), always ready
//
// One input pixel per cycle while in_pix.ready is high. For the odd-row, odd-column
// pixel that completes a block, the line store read and then the sum are registered. Reset
// (synchronous, rst_n low) clears counters, held pixel and valid flags; the line store
// is not cleared, as every entry is written on an even row before the odd row reads it.
// in_pix.ready drops only while output and add stages are full and out_avg.ready is low.
module box_downsample_2x2 #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  bds_pix_if.sink      in_pix,
  bds_avg_if.source    out_avg,
  bds_cfg_if.sink      cfg_wr
);
  import bds_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int SB    = SAMPLE_BITS;
  localparam int PW    = SB + 1;
  localparam int DW    = 3 * PW;

  logic [CW-1:0] wlast, wlast_even;
  frm_cfg_t      frm;

  bds_cfg_regs #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_wr),
    .wlast      (wlast),
    .wlast_even (wlast_even),
    .frm        (frm)
  );

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [SB-1:0]    held_a_r, held_b_r, held_c_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic [DW-1:0]    s1_pair_r;
  logic             s1_last_r;
  logic             out_valid_r, out_valid_nxt;
  avg_t             out_data_r;

  logic          accept, s1_adv, col_wrap, odd_col;
  logic [SB-1:0] px_a, px_b, px_c;
  logic [PW-1:0] pair_a, pair_b, pair_c;
  logic [DW-1:0] pair_word, up_word;
  logic          wr_en, rd_en;
  logic [AW-1:0] idx;
  logic [PW:0]   sum_a, sum_b, sum_c;

  assign s1_adv        = s1_valid_r && (!out_valid_r || out_avg.ready);
  assign in_pix.ready  = !s1_valid_r || !out_valid_r || out_avg.ready;
  assign accept        = in_pix.valid && in_pix.ready;

  assign px_a = in_pix.data.chan_a[SB-1:0];
  assign px_b = frm.color ? in_pix.data.chan_b[SB-1:0] : '0;
  assign px_c = frm.color ? in_pix.data.chan_c[SB-1:0] : '0;

  assign odd_col  = col_r[0];
  assign col_wrap = col_r >= wlast;
  assign idx      = AW'(col_r >> 1);

  assign pair_a    = PW'(held_a_r) + PW'(px_a);
  assign pair_b    = PW'(held_b_r) + PW'(px_b);
  assign pair_c    = PW'(held_c_r) + PW'(px_c);
  assign pair_word = {pair_c, pair_b, pair_a};

  assign wr_en = accept && odd_col && !row_r[0];
  assign rd_en = accept && odd_col && row_r[0];

  bds_line_mem #(.DEPTH(DEPTH), .DW(DW)) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (pair_word),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (up_word)
  );

  // advance the raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = (row_r >= frm.hlast) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_adv) s1_valid_nxt = 1'b0;
    if (rd_en) s1_valid_nxt = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_avg.ready) out_valid_nxt = 1'b0;
    if (s1_adv) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      held_a_r    <= '0;
      held_b_r    <= '0;
      held_c_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && !odd_col && !col_wrap) begin
        held_a_r <= px_a;
        held_b_r <= px_b;
        held_c_r <= px_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pair_r <= pair_word;
      s1_last_r <= (row_r == frm.hlast_even) && (col_r == wlast_even);
    end
  end

  assign sum_a = (PW+1)'(up_word[PW-1:0])      + (PW+1)'(s1_pair_r[PW-1:0]);
  assign sum_b = (PW+1)'(up_word[2*PW-1:PW])   + (PW+1)'(s1_pair_r[2*PW-1:PW]);
  assign sum_c = (PW+1)'(up_word[3*PW-1:2*PW]) + (PW+1)'(s1_pair_r[3*PW-1:2*PW]);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.avg_a      <= SAMPLE_W'(sum_a[PW:2]);
      out_data_r.avg_b      <= SAMPLE_W'(sum_b[PW:2]);
      out_data_r.avg_c      <= SAMPLE_W'(sum_c[PW:2]);
      out_data_r.frame_last <= s1_last_r;
    end
  end

  assign out_avg.valid = out_valid_r;
  assign out_avg.data  = out_data_r;

endmodule
